@@ rtl/lru_order_tracker_macros.svh @@
// assertion macros used by the checker file lot_checker.sv
`ifndef LRU_ORDER_TRACKER_MACROS_SVH
`define LRU_ORDER_TRACKER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LOT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lot_pkg.sv @@
// ----------------------------------------------------------------------------
// lot_pkg
// Shared widths, operation and status codes for the LRU order tracker.
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam int KIND_W      = 2;
    localparam int ID_W        = 8;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = 9;
    localparam int CAP_W       = 9;
    localparam int NUM_IDS_DEF = 256;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [CAP_W-1:0]  t_cap;

    localparam t_cap CAP_RESET = 9'd256;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_TOUCH  = 2'd1;
    localparam t_kind KIND_REMOVE = 2'd2;
    localparam t_kind KIND_POP    = 2'd3;

    localparam t_status STAT_OK          = 2'd0;
    localparam t_status STAT_NOT_PRESENT = 2'd1;
    localparam t_status STAT_DUPLICATE   = 2'd2;
    localparam t_status STAT_EMPTY       = 2'd3;

endpackage

@@ rtl/lot_in_if.sv @@
// ----------------------------------------------------------------------------
// lot_in_if
// Operation channel: kind and entry id with valid/ready.
// ----------------------------------------------------------------------------
interface lot_in_if import lot_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_id   entry_id;

    modport source (output valid, output kind, output entry_id, input ready);
    modport sink   (input valid, input kind, input entry_id, output ready);
endinterface

@@ rtl/lot_out_if.sv @@
// ----------------------------------------------------------------------------
// lot_out_if
// Result channel: status, evicted id and resident count with valid/ready.
// ----------------------------------------------------------------------------
interface lot_out_if import lot_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    logic    evicted_valid;
    t_id     evicted_id;
    t_count  count;

    modport source (output valid, output status, output evicted_valid,
                    output evicted_id, output count, input ready);
    modport sink   (input valid, input status, input evicted_valid,
                    input evicted_id, input count, output ready);
endinterface

@@ rtl/lot_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lot_cfg_if
// Configuration write channel carrying the capacity register value.
// ----------------------------------------------------------------------------
interface lot_cfg_if import lot_pkg::*; ();
    logic valid;
    logic ready;
    t_cap data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lot_link_mem.sv @@
// ----------------------------------------------------------------------------
// lot_link_mem
// Newer and older neighbor link memories, one write and one registered
// read port each, both read at the same address.
// ----------------------------------------------------------------------------
module lot_link_mem import lot_pkg::*; #(
    parameter int NUM_IDS = NUM_IDS_DEF,
    parameter int LW      = $clog2(NUM_IDS)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [LW-1:0] i_rd_addr,
    output logic [LW-1:0] o_rd_newer,
    output logic [LW-1:0] o_rd_older,
    input  logic          i_nw_en,
    input  logic [LW-1:0] i_nw_addr,
    input  logic [LW-1:0] i_nw_data,
    input  logic          i_ow_en,
    input  logic [LW-1:0] i_ow_addr,
    input  logic [LW-1:0] i_ow_data
);

    logic [LW-1:0] r_newer_mem [NUM_IDS];
    logic [LW-1:0] r_older_mem [NUM_IDS];
    logic [LW-1:0] r_rd_newer;
    logic [LW-1:0] r_rd_older;

    always_ff @(posedge i_clk) begin
        if (i_nw_en) begin
            r_newer_mem[i_nw_addr] <= i_nw_data;
        end
        if (i_rd_en) begin
            r_rd_newer <= r_newer_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ow_en) begin
            r_older_mem[i_ow_addr] <= i_ow_data;
        end
        if (i_rd_en) begin
            r_rd_older <= r_older_mem[i_rd_addr];
        end
    end

    // read data holds until the next read
    assign o_rd_newer = r_rd_newer;
    assign o_rd_older = r_rd_older;

endmodule

@@ rtl/lot_ctrl.sv @@
// ----------------------------------------------------------------------------
// lot_ctrl
// Operation sequencer: decodes a transaction, reads the links of the entry
// being unlinked, updates head, tail, count and resident flags, writes the
// neighbor links back and registers the result.
// ----------------------------------------------------------------------------
module lot_ctrl import lot_pkg::*; #(
    parameter int NUM_IDS = NUM_IDS_DEF,
    parameter int LW      = $clog2(NUM_IDS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cap             i_capacity,
    lot_in_if.sink           i_in,
    lot_out_if.source        o_out,
    output logic             o_rd_en,
    output logic [LW-1:0]    o_rd_addr,
    input  logic [LW-1:0]    i_rd_newer,
    input  logic [LW-1:0]    i_rd_older,
    output logic             o_nw_en,
    output logic [LW-1:0]    o_nw_addr,
    output logic [LW-1:0]    o_nw_data,
    output logic             o_ow_en,
    output logic [LW-1:0]    o_ow_addr,
    output logic [LW-1:0]    o_ow_data
);

    localparam int CW    = $clog2(NUM_IDS + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [NUM_IDS-1:0] r_resident;
    logic [LW-1:0]      r_head, r_tail;
    logic [CW-1:0]      r_cnt;

    // per-transaction plan
    logic [LW-1:0]      r_x, r_id;
    logic               r_unlink, r_push, r_ev_valid;
    t_status            r_status;

    // result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_ev_valid;
    t_id                r_out_ev_id;
    t_count             r_out_count;

    logic               accept, adv;
    logic               in_range, present, full;
    logic [LW-1:0]      id_lw;
    logic [CMP_W-1:0]   cap_eff;

    t_status            d_status;
    logic               d_unlink, d_push, d_ev_valid;
    logic [LW-1:0]      d_x;

    logic [LW-1:0]      h1, t1, h2, t2;
    logic [CW-1:0]      c1, c2;
    logic               mid;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign adv        = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);

    // ---------------- decode at accept ----------------
    assign id_lw    = LW'(i_in.entry_id);
    assign in_range = int'(i_in.entry_id) < NUM_IDS;
    assign present  = in_range && r_resident[id_lw];

    always_comb begin
        cap_eff = (i_capacity == '0) ? CMP_W'(1) : CMP_W'(i_capacity);
        if (cap_eff > CMP_W'(NUM_IDS)) begin
            cap_eff = CMP_W'(NUM_IDS);
        end
    end

    assign full = CMP_W'(r_cnt) >= cap_eff;

    always_comb begin
        d_status   = STAT_OK;
        d_unlink   = 1'b0;
        d_push     = 1'b0;
        d_ev_valid = 1'b0;
        d_x        = r_tail;
        unique case (i_in.kind)
            KIND_INSERT: begin
                if (!in_range) begin
                    d_status = STAT_NOT_PRESENT;
                end else if (present) begin
                    d_status = STAT_DUPLICATE;
                end else begin
                    d_push     = 1'b1;
                    d_unlink   = full && (r_cnt != '0);
                    d_ev_valid = full && (r_cnt != '0);
                end
            end
            KIND_TOUCH: begin
                if (!present) begin
                    d_status = STAT_NOT_PRESENT;
                end else if (id_lw != r_head) begin
                    d_unlink = 1'b1;
                    d_push   = 1'b1;
                    d_x      = id_lw;
                end
            end
            KIND_REMOVE: begin
                if (!present) begin
                    d_status = STAT_NOT_PRESENT;
                end else begin
                    d_unlink = 1'b1;
                    d_x      = id_lw;
                end
            end
            KIND_POP: begin
                if (r_cnt == '0) begin
                    d_status = STAT_EMPTY;
                end else begin
                    d_unlink   = 1'b1;
                    d_ev_valid = 1'b1;
                end
            end
            default: begin
                d_status = STAT_OK;
            end
        endcase
    end

    // links of the entry to unlink arrive in the cycle after accept
    assign o_rd_en   = accept && d_unlink;
    assign o_rd_addr = d_x;

    // ---------------- execute ----------------
    always_comb begin
        h1  = r_head;
        t1  = r_tail;
        c1  = r_cnt;
        mid = 1'b0;
        if (r_unlink) begin
            if (r_cnt <= CW'(1)) begin
                h1 = '0;
                t1 = '0;
            end else if (r_x == r_head) begin
                h1 = i_rd_older;
            end else if (r_x == r_tail) begin
                t1 = i_rd_newer;
            end else begin
                mid = 1'b1;
            end
            c1 = r_cnt - CW'(1);
        end
        h2 = h1;
        t2 = t1;
        c2 = c1;
        if (r_push) begin
            if (c1 == '0) begin
                t2 = r_id;
            end
            h2 = r_id;
            c2 = c1 + CW'(1);
        end
    end

    // push links go first; a middle unlink patches its neighbors, in state S_WR2
    // when both are needed (the two never touch the same word)
    always_comb begin
        o_nw_en   = 1'b0;
        o_nw_addr = i_rd_older;
        o_nw_data = i_rd_newer;
        o_ow_en   = 1'b0;
        o_ow_addr = i_rd_newer;
        o_ow_data = i_rd_older;
        if (adv) begin
            if (r_push && (c1 != '0)) begin
                o_nw_en   = 1'b1;
                o_nw_addr = h1;
                o_nw_data = r_id;
                o_ow_en   = 1'b1;
                o_ow_addr = r_id;
                o_ow_data = h1;
            end else if (mid) begin
                o_nw_en = 1'b1;
                o_ow_en = 1'b1;
            end
        end else if (r_state == S_WR2) begin
            o_nw_en = 1'b1;
            o_ow_en = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (adv) begin
                    n_state = (mid && r_push) ? S_WR2 : S_IDLE;
                end
            end
            S_WR2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_resident <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_head <= h2;
                r_tail <= t2;
                r_cnt  <= c2;
                if (r_unlink) begin
                    r_resident[r_x] <= 1'b0;
                end
                if (r_push) begin
                    r_resident[r_id] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x        <= d_x;
            r_id       <= id_lw;
            r_unlink   <= d_unlink;
            r_push     <= d_push;
            r_ev_valid <= d_ev_valid;
            r_status   <= d_status;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_status   <= r_status;
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_id    <= r_ev_valid ? ID_W'(r_x) : '0;
            r_out_count    <= CNT_W'(c2);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.evicted_valid = r_out_ev_valid;
    assign o_out.evicted_id    = r_out_ev_id;
    assign o_out.count         = r_out_count;

endmodule

@@ rtl/lru_order_tracker.sv @@
// ----------------------------------------------------------------------------
// lru_order_tracker
// Least-recently-used order over resident entry ids, kept as a doubly linked
// list in two link memories, with head, tail, count and resident flags.
// ----------------------------------------------------------------------------
// channel   direction  transaction carries
// i_in      in         kind, entry_id
// o_out     out        status, evicted_valid, evicted_id, count
// i_cfg     in         capacity (data)
//
// an operation passes through accept (link read issued) and execute
// (result registered); a touch of an entry in the middle of the list adds
// state S_WR2 for the second write on each link memory port.
// reset clears head, tail, count and resident flags at once; no clearing pass.
// execute waits while the result register is full and not being taken.
// ----------------------------------------------------------------------------
module lru_order_tracker import lot_pkg::*; #(
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lot_cfg_if.sink    i_cfg,
    lot_in_if.sink     i_in,
    lot_out_if.source  o_out
);

    localparam int LW = $clog2(NUM_IDS);

    t_cap          r_capacity;
    logic          rd_en;
    logic [LW-1:0] rd_addr, rd_newer, rd_older;
    logic          nw_en, ow_en;
    logic [LW-1:0] nw_addr, nw_data, ow_addr, ow_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    lot_ctrl #(
        .NUM_IDS (NUM_IDS),
        .LW      (LW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_newer (rd_newer),
        .i_rd_older (rd_older),
        .o_nw_en    (nw_en),
        .o_nw_addr  (nw_addr),
        .o_nw_data  (nw_data),
        .o_ow_en    (ow_en),
        .o_ow_addr  (ow_addr),
        .o_ow_data  (ow_data)
    );

    lot_link_mem #(
        .NUM_IDS (NUM_IDS),
        .LW      (LW)
    ) u_link_mem (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_newer (rd_newer),
        .o_rd_older (rd_older),
        .i_nw_en    (nw_en),
        .i_nw_addr  (nw_addr),
        .i_nw_data  (nw_data),
        .i_ow_en    (ow_en),
        .i_ow_addr  (ow_addr),
        .i_ow_data  (ow_data)
    );

endmodule

@@ rtl/lot_checker.sv @@
// ----------------------------------------------------------------------------
// lot_checker
// Port-level checks on the result channel of the LRU order tracker.
// ----------------------------------------------------------------------------
`include "lru_order_tracker_macros.svh"

module lot_checker import lot_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_status i_out_status,
    input logic    i_out_ev_valid,
    input t_id     i_out_ev_id,
    input t_count  i_out_count
);

    `LOT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_ev_id) && $stable(i_out_count), "result changed while stalled")
    `LOT_ASSERT_SAME(a_evict_ok, i_out_valid && i_out_ev_valid, i_out_status == STAT_OK, "eviction reported with error status")
    `LOT_ASSERT_SAME(a_evict_id_zero, i_out_valid && !i_out_ev_valid, i_out_ev_id == '0, "evicted id not zero without eviction")
    `LOT_ASSERT_SAME(a_empty_count, i_out_valid && (i_out_status == STAT_EMPTY), (i_out_count == '0) && !i_out_ev_valid, "empty pop with nonzero count")

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_ev_valid (o_out.evicted_valid),
    .i_out_ev_id    (o_out.evicted_id),
    .i_out_count    (o_out.count)
);
